// ----- rtl/qfs_pkg.sv -----
// shared types, constants and codes of the quoted field splitter
`timescale 1ns / 1ps

package qfs_pkg;

  // string length limit and position width
  localparam int MaxLen = 65536;
  localparam int PosW   = $clog2(MaxLen + 1);

  // field widths
  localparam int ChW      = 8;
  localparam int StartW   = 16;
  localparam int LenW     = 17;
  localparam int TotW     = 16;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 1;

  // result queue depth and its fill count width
  localparam int QDepth = 2;
  localparam int FillW  = $clog2(QDepth + 1);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDelim  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxTok = 1'b1;

  // reset values of the configuration registers
  localparam logic [ChW-1:0]    DelimReset  = 8'd44;
  localparam logic [StartW-1:0] MaxTokReset = '0;

  // special bytes
  localparam logic [ChW-1:0] ChSpace  = 8'h20;
  localparam logic [ChW-1:0] ChTab    = 8'h09;
  localparam logic [ChW-1:0] ChSquote = 8'h27;
  localparam logic [ChW-1:0] ChDquote = 8'h22;

  // record kinds
  localparam logic KindToken = 1'b0;
  localparam logic KindEnd   = 1'b1;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_LEAD    = 3'd0,
    MODE_UNQ     = 3'd1,
    MODE_QUO     = 3'd2,
    MODE_AFTERQ  = 3'd3,
    MODE_DELIMS  = 3'd4,
    MODE_TRAILWS = 3'd5
  } mode_e;

  // one input item
  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           last;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic              kind;
    logic [StartW-1:0] token_start;
    logic [LenW-1:0]   token_length;
    logic [LenW-1:0]   stop_position;
    logic [TotW-1:0]   token_total;
    logic              overflow;
    logic              last_of_run;
  } rec_t;

  // records produced by one byte, in order, and how many are valid
  typedef struct packed {
    rec_t             r0;
    rec_t             r1;
    logic [FillW-1:0] n;
  } push_t;

endpackage

// ----- rtl/qfs_in_stage.sv -----
// input register of the quoted field splitter
`timescale 1ns / 1ps

module qfs_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qfs_pkg::in_item_t item_i,
  input  logic              adv_i,
  output logic              vld_o,
  output qfs_pkg::in_item_t item_o
);

  logic              vld_q, vld_d;
  qfs_pkg::in_item_t item_q;
  logic              take;

  // hold while the registered item cannot move on
  assign in_stall_o = vld_q & ~adv_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ----- rtl/qfs_parser.sv -----
// scanner state, configuration registers and per-byte record builder
`timescale 1ns / 1ps

module qfs_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qfs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [qfs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  qfs_pkg::in_item_t             item_i,
  input  logic                          adv_i,
  output qfs_pkg::push_t                push_o
);

  // configuration
  logic [qfs_pkg::ChW-1:0]    delim_q;
  logic [qfs_pkg::StartW-1:0] max_tok_q;

  // scanner state
  qfs_pkg::mode_e             mode_q, mode_d;
  logic [qfs_pkg::PosW-1:0]   pos_q, pos_d;
  logic [qfs_pkg::PosW-1:0]   fstart_q, fstart_d;
  logic [qfs_pkg::PosW-1:0]   fend_q, fend_d;
  logic                       dq_q, dq_d;
  logic [qfs_pkg::TotW-1:0]   ntok_q, ntok_d;
  logic                       stopped_q, stopped_d;
  logic [qfs_pkg::PosW-1:0]   stop_at_q, stop_at_d;
  logic                       ovf_q, ovf_d;

  // intermediate values after the byte itself
  qfs_pkg::mode_e             t_mode;
  logic [qfs_pkg::PosW-1:0]   t_fstart, t_fend, t_stop_at, t_pos;
  logic                       t_dq, t_stopped, t_ovf;
  logic [qfs_pkg::TotW-1:0]   t_ntok;

  logic [qfs_pkg::ChW-1:0]    c, qc;
  logic [qfs_pkg::PosW-1:0]   p_inc;
  logic                       in_range, blank, is_quote, is_delim, limit_hit, lead_go;
  logic                       emit_a, emit_b, tok_emit;
  logic [qfs_pkg::PosW-1:0]   a_len, b_len, tok_len, stop_pos;
  qfs_pkg::rec_t              tok_rec, end_rec;

  // byte classification
  assign c         = item_i.ch;
  assign p_inc     = pos_q + qfs_pkg::PosW'(1);
  assign in_range  = pos_q < qfs_pkg::PosW'(qfs_pkg::MaxLen);
  assign blank     = (c == qfs_pkg::ChSpace) || (c == qfs_pkg::ChTab);
  assign is_quote  = (c == qfs_pkg::ChSquote) || (c == qfs_pkg::ChDquote);
  assign is_delim  = (c == delim_q);
  assign qc        = dq_q ? qfs_pkg::ChDquote : qfs_pkg::ChSquote;
  assign limit_hit = (max_tok_q != '0) && (ntok_q >= max_tok_q);

  // mode step for the current byte
  always_comb begin
    t_mode    = mode_q;
    t_fstart  = fstart_q;
    t_fend    = fend_q;
    t_dq      = dq_q;
    t_stopped = stopped_q;
    t_stop_at = stop_at_q;
    emit_a    = 1'b0;
    a_len     = '0;
    lead_go   = 1'b0;
    if (in_range && !stopped_q) begin
      unique case (mode_q)
        qfs_pkg::MODE_LEAD: begin
          lead_go = ~blank;
        end
        qfs_pkg::MODE_UNQ: begin
          if (is_delim) begin
            emit_a = fend_q > fstart_q;
            a_len  = fend_q - fstart_q;
            t_mode = qfs_pkg::MODE_DELIMS;
          end else if (!blank) begin
            t_fend = p_inc;
          end
        end
        qfs_pkg::MODE_QUO: begin
          if (c == qc) begin
            emit_a = pos_q > fstart_q;
            a_len  = pos_q - fstart_q;
            t_mode = qfs_pkg::MODE_AFTERQ;
          end
        end
        qfs_pkg::MODE_AFTERQ: begin
          if (is_delim) begin
            t_mode = qfs_pkg::MODE_DELIMS;
          end
        end
        qfs_pkg::MODE_DELIMS, qfs_pkg::MODE_TRAILWS: begin
          // a delimiter run continues, otherwise skip blanks, stop at the token limit or open the next field
          if (!(mode_q == qfs_pkg::MODE_DELIMS && is_delim)) begin
            if (blank) begin
              t_mode = qfs_pkg::MODE_TRAILWS;
            end else if (limit_hit) begin
              t_stopped = 1'b1;
              t_stop_at = pos_q;
              t_mode    = qfs_pkg::MODE_TRAILWS;
            end else begin
              lead_go = 1'b1;
            end
          end
        end
        default: begin
          t_mode = mode_q;
        end
      endcase
      // field opens on a non-blank byte
      if (lead_go) begin
        if (is_quote) begin
          t_dq     = (c == qfs_pkg::ChDquote);
          t_fstart = p_inc;
          t_mode   = qfs_pkg::MODE_QUO;
        end else begin
          t_fstart = pos_q;
          if (is_delim) begin
            t_fend = pos_q;
            t_mode = qfs_pkg::MODE_DELIMS;
          end else begin
            t_fend = p_inc;
            t_mode = qfs_pkg::MODE_UNQ;
          end
        end
      end
    end
  end

  // end of string: pending field, counters and records
  always_comb begin
    t_pos  = in_range ? p_inc : pos_q;
    t_ovf  = ovf_q | ~in_range;
    emit_b = 1'b0;
    b_len  = '0;
    if (item_i.last && !t_stopped) begin
      if (t_mode == qfs_pkg::MODE_UNQ && t_fend > t_fstart) begin
        emit_b = 1'b1;
        b_len  = t_fend - t_fstart;
      end else if (t_mode == qfs_pkg::MODE_QUO && t_pos > t_fstart) begin
        emit_b = 1'b1;
        b_len  = t_pos - t_fstart;
      end
    end
    tok_emit = emit_a | emit_b;
    tok_len  = emit_a ? a_len : b_len;
    t_ntok   = (tok_emit && ntok_q != '1) ? ntok_q + qfs_pkg::TotW'(1) : ntok_q;
    stop_pos = t_stopped ? t_stop_at : t_pos;

    tok_rec               = '0;
    tok_rec.kind          = qfs_pkg::KindToken;
    tok_rec.token_start   = t_fstart[qfs_pkg::StartW-1:0];
    tok_rec.token_length  = qfs_pkg::LenW'(tok_len);
    tok_rec.last_of_run   = ~item_i.last;

    end_rec               = '0;
    end_rec.kind          = qfs_pkg::KindEnd;
    end_rec.stop_position = qfs_pkg::LenW'(stop_pos);
    end_rec.token_total   = t_ntok;
    end_rec.overflow      = t_ovf;
    end_rec.last_of_run   = 1'b1;

    push_o.r0 = tok_emit ? tok_rec : end_rec;
    push_o.r1 = end_rec;
    push_o.n  = qfs_pkg::FillW'(tok_emit) + qfs_pkg::FillW'(item_i.last);
  end

  // next state, rearmed after the last byte
  always_comb begin
    if (item_i.last) begin
      mode_d    = qfs_pkg::MODE_LEAD;
      pos_d     = '0;
      fstart_d  = '0;
      fend_d    = '0;
      dq_d      = 1'b0;
      ntok_d    = '0;
      stopped_d = 1'b0;
      stop_at_d = '0;
      ovf_d     = 1'b0;
    end else begin
      mode_d    = t_mode;
      pos_d     = t_pos;
      fstart_d  = t_fstart;
      fend_d    = t_fend;
      dq_d      = t_dq;
      ntok_d    = t_ntok;
      stopped_d = t_stopped;
      stop_at_d = t_stop_at;
      ovf_d     = t_ovf;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q   <= qfs_pkg::DelimReset;
      max_tok_q <= qfs_pkg::MaxTokReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == qfs_pkg::CfgDelim) begin
        delim_q <= cfg_wdata_i[qfs_pkg::ChW-1:0];
      end else if (cfg_index_i == qfs_pkg::CfgMaxTok) begin
        max_tok_q <= cfg_wdata_i[qfs_pkg::StartW-1:0];
      end
    end
  end

  // scanner state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= qfs_pkg::MODE_LEAD;
      pos_q     <= '0;
      fstart_q  <= '0;
      fend_q    <= '0;
      dq_q      <= 1'b0;
      ntok_q    <= '0;
      stopped_q <= 1'b0;
      stop_at_q <= '0;
      ovf_q     <= 1'b0;
    end else if (adv_i) begin
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      fstart_q  <= fstart_d;
      fend_q    <= fend_d;
      dq_q      <= dq_d;
      ntok_q    <= ntok_d;
      stopped_q <= stopped_d;
      stop_at_q <= stop_at_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

// ----- rtl/qfs_out_queue.sv -----
// two-entry result queue that takes up to two records and gives one a cycle when popped
`timescale 1ns / 1ps

module qfs_out_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_en_i,
  input  qfs_pkg::push_t               push_i,
  input  logic                         pop_i,
  output qfs_pkg::rec_t                head_o,
  output logic [qfs_pkg::FillW-1:0]    fill_o
);

  logic [qfs_pkg::FillW-1:0] fill_q, fill_d, rem;
  logic [qfs_pkg::FillW-1:0] n_in;
  qfs_pkg::rec_t             s0_q, s0_d, s1_q, s1_d;

  assign n_in = push_en_i ? push_i.n : '0;
  assign rem  = fill_q - qfs_pkg::FillW'(pop_i);

  // shift out the head, then append behind what remains
  always_comb begin
    s0_d = s0_q;
    s1_d = s1_q;
    if (pop_i) begin
      s0_d = s1_q;
    end
    if (n_in != '0) begin
      if (rem == '0) begin
        s0_d = push_i.r0;
        s1_d = push_i.r1;
      end else begin
        s1_d = push_i.r0;
      end
    end
    fill_d = rem + n_in;
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // record slots
  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign head_o = s0_q;
  assign fill_o = fill_q;

endmodule

// ----- rtl/quoted_field_splitter_core.sv -----
// top level of the quoted field splitter
//
//  channel | direction | handshake              | payload
//  in      | to block  | in_valid_i / in_stall_o | in_ch_i, in_last_i
//  out     | from block| out_valid_o / out_stall_i| kind, token start and length, end record
//  cfg     | to block  | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// one byte is taken per cycle unless stalled; its records pass the input register and the
// result queue before they are read out; a byte that closes a field and ends the string
// gives two records; the pair only enters an empty result queue, so with a free-running
// output the input can stall; it stalls only when the registered item's records
// do not fit in the result queue, never directly on out_stall_i
// reset clears the scanner, the configuration, the input register and the result queue
`timescale 1ns / 1ps

module quoted_field_splitter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qfs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [qfs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [qfs_pkg::ChW-1:0]       in_ch_i,
  input  logic                          in_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_kind_o,
  output logic [qfs_pkg::StartW-1:0]    out_token_start_o,
  output logic [qfs_pkg::LenW-1:0]      out_token_length_o,
  output logic [qfs_pkg::LenW-1:0]      out_stop_position_o,
  output logic [qfs_pkg::TotW-1:0]      out_token_total_o,
  output logic                          out_overflow_o,
  output logic                          out_last_of_run_o
);

  qfs_pkg::in_item_t         in_item, item_q;
  logic                      item_vld, adv, pop;
  qfs_pkg::push_t            push;
  qfs_pkg::rec_t             head;
  logic [qfs_pkg::FillW-1:0] fill;

  assign in_item.ch   = in_ch_i;
  assign in_item.last = in_last_i;

  // input register
  qfs_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .vld_o      (item_vld),
    .item_o     (item_q)
  );

  // scanner
  qfs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_q),
    .adv_i       (adv),
    .push_o      (push)
  );

  // the registered item moves on when its records fit in the queue
  assign adv = item_vld && (push.n <= (qfs_pkg::FillW'(qfs_pkg::QDepth) - fill));
  assign pop = out_valid_o & ~out_stall_i;

  // result queue
  qfs_out_queue u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (adv),
    .push_i    (push),
    .pop_i     (pop),
    .head_o    (head),
    .fill_o    (fill)
  );

  assign out_valid_o         = (fill != '0);
  assign out_kind_o          = head.kind;
  assign out_token_start_o   = head.token_start;
  assign out_token_length_o  = head.token_length;
  assign out_stop_position_o = head.stop_position;
  assign out_token_total_o   = head.token_total;
  assign out_overflow_o      = head.overflow;
  assign out_last_of_run_o   = head.last_of_run;

  // queue never holds more than its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= qfs_pkg::FillW'(qfs_pkg::QDepth))
    else $error("result queue overfilled");

  // a pair of records only enters an empty queue
  a_pair_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && push.n == qfs_pkg::FillW'(2) |-> fill == '0)
    else $error("record pair pushed into busy queue");

  // end records always close the run of their byte
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == qfs_pkg::KindEnd |-> out_last_of_run_o)
    else $error("end record not last of run");

  // empty fields are never reported
  a_tok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == qfs_pkg::KindToken |-> out_token_length_o != '0)
    else $error("zero-length token record");

endmodule

// ----- sim/tb.sv -----
// self-checking testbench of the quoted field splitter core
`timescale 1ns / 1ps

module tb;
  import qfs_pkg::*;

  localparam int CycleLimit = 1500000;
  localparam int PhaseBytes = 135;

  // fixed register settings, extremes and awkward delimiters among them
  localparam int NumFixed = 10;
  localparam logic [ChW-1:0] FixedDelim [NumFixed] = '{
    8'd44, ChSpace, ChDquote, ChTab, ChSquote, 8'd0, 8'd255, 8'd59, 8'd44, 8'd124
  };
  localparam logic [StartW-1:0] FixedLimit [NumFixed] = '{
    16'd1, 16'd2, 16'd0, 16'd3, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd0
  };
  localparam int PressurePhase = 8;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [ChW-1:0]      in_ch;
  logic                in_last;
  logic                out_valid;
  logic                out_stall;
  logic                out_kind;
  logic [StartW-1:0]   out_token_start;
  logic [LenW-1:0]     out_token_length;
  logic [LenW-1:0]     out_stop_position;
  logic [TotW-1:0]     out_token_total;
  logic                out_overflow;
  logic                out_last_of_run;

  quoted_field_splitter_core dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_ch_i             (in_ch),
    .in_last_i           (in_last),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_kind_o          (out_kind),
    .out_token_start_o   (out_token_start),
    .out_token_length_o  (out_token_length),
    .out_stop_position_o (out_stop_position),
    .out_token_total_o   (out_token_total),
    .out_overflow_o      (out_overflow),
    .out_last_of_run_o   (out_last_of_run)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // byte items waiting to be sent and field records still to come
  in_item_t pending_bytes[$];
  rec_t     expected_recs[$];
  rec_t     byte_recs[$];
  int       bytes_queued;
  int       mismatches;
  int       cycle_count;

  // handshake bookkeeping shared by the processes
  logic byte_taken;
  logic rec_taken;
  bit   rush;
  int   pressure_req;

  // splitter state as this side expects it
  logic [ChW-1:0]    delim;
  logic [StartW-1:0] max_tok;
  mode_e             scan_mode;
  logic [LenW-1:0]   pos;
  logic [LenW-1:0]   fstart;
  logic [LenW-1:0]   fend;
  logic              dquote;
  logic [TotW-1:0]   found;
  logic              halted;
  logic [LenW-1:0]   stop_at;
  logic              ovf_seen;

  function automatic bit is_blank(input logic [ChW-1:0] c);
    return c == ChSpace || c == ChTab;
  endfunction

  task automatic clear_string();
    scan_mode = MODE_LEAD;
    pos       = '0;
    fstart    = '0;
    fend      = '0;
    dquote    = 1'b0;
    found     = '0;
    halted    = 1'b0;
    stop_at   = '0;
    ovf_seen  = 1'b0;
  endtask

  task automatic push_token(input logic [LenW-1:0] start, input logic [LenW-1:0] len);
    rec_t r;
    r = '0;
    r.kind         = KindToken;
    r.token_start  = start[StartW-1:0];
    r.token_length = len;
    byte_recs.insert(byte_recs.size(), r);
    if (found != '1) found = found + TotW'(1);
  endtask

  // walk one byte through the scanner modes until it settles
  task automatic scan_byte(input logic [ChW-1:0] c);
    logic [LenW-1:0] p;
    bit              done;
    int              g;
    p    = pos;
    done = 0;
    for (g = 0; g < 8 && !done && !halted; g++) begin
      case (scan_mode)
        MODE_LEAD: begin
          if (is_blank(c)) begin
            done = 1;
          end else if (c == ChSquote || c == ChDquote) begin
            dquote    = (c == ChDquote);
            fstart    = p + LenW'(1);
            scan_mode = MODE_QUO;
            done      = 1;
          end else begin
            fstart    = p;
            fend      = p;
            scan_mode = MODE_UNQ;
          end
        end
        MODE_UNQ: begin
          if (c == delim) begin
            if (fend > fstart) push_token(fstart, fend - fstart);
            scan_mode = MODE_DELIMS;
          end else begin
            if (!is_blank(c)) fend = p + LenW'(1);
            done = 1;
          end
        end
        MODE_QUO: begin
          if (c == (dquote ? ChDquote : ChSquote)) begin
            if (p > fstart) push_token(fstart, p - fstart);
            scan_mode = MODE_AFTERQ;
          end
          done = 1;
        end
        MODE_AFTERQ: begin
          if (c != delim) done = 1;
          else scan_mode = MODE_DELIMS;
        end
        MODE_DELIMS: begin
          if (c == delim) done = 1;
          else scan_mode = MODE_TRAILWS;
        end
        default: begin
          if (is_blank(c)) begin
            done = 1;
          end else if (max_tok != '0 && found >= max_tok) begin
            halted  = 1'b1;
            stop_at = p;
            done    = 1;
          end else begin
            scan_mode = MODE_LEAD;
          end
        end
      endcase
    end
  endtask

  // records that one accepted byte must produce, queued in order
  task automatic predict_records(input in_item_t b);
    rec_t r;
    byte_recs.delete();
    if (pos >= LenW'(MaxLen)) begin
      ovf_seen = 1'b1;
    end else begin
      scan_byte(b.ch);
      pos = pos + LenW'(1);
    end
    if (b.last) begin
      if (!halted) begin
        if (scan_mode == MODE_UNQ && fend > fstart) push_token(fstart, fend - fstart);
        else if (scan_mode == MODE_QUO && pos > fstart) push_token(fstart, pos - fstart);
      end
      r = '0;
      r.kind          = KindEnd;
      r.stop_position = halted ? stop_at : pos;
      r.token_total   = found;
      r.overflow      = ovf_seen;
      byte_recs.insert(byte_recs.size(), r);
      clear_string();
    end
    if (byte_recs.size() > 0) byte_recs[byte_recs.size() - 1].last_of_run = 1'b1;
    foreach (byte_recs[i]) expected_recs.insert(expected_recs.size(), byte_recs[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // input acceptance, prediction and record checking on the rising edge
  always @(posedge clk) begin : watch_ports
    rec_t want;
    byte_taken <= in_valid && !in_stall;
    rec_taken  <= out_valid && !out_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_records('{ch: in_ch, last: in_last});
      if (out_valid && !out_stall) begin
        if (expected_recs.size() == 0) begin
          $error("record with nothing expected: kind %0d start %0d length %0d",
                 out_kind, out_token_start, out_token_length);
          mismatches++;
        end else begin
          want = expected_recs.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("token_start", 32'(want.token_start), 32'(out_token_start));
          check_field("token_length", 32'(want.token_length), 32'(out_token_length));
          check_field("stop_position", 32'(want.stop_position), 32'(out_stop_position));
          check_field("token_total", 32'(want.token_total), 32'(out_token_total));
          check_field("overflow", 32'(want.overflow), 32'(out_overflow));
          check_field("last_of_run", 32'(want.last_of_run), 32'(out_last_of_run));
        end
      end
    end
  end

  // byte driver with a random gap after each item
  always @(negedge clk) begin : drive_bytes
    in_item_t nxt;
    int       gap_left;
    bit       tx_calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (in_valid && !byte_taken) begin
      // stalled item stays as it is
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_bytes.size() > 0) begin
      nxt = pending_bytes.pop_front();
      in_ch    <= nxt.ch;
      in_last  <= nxt.last;
      in_valid <= 1'b1;
      if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      gap_left = (rush || tx_calm) ? 0 : $urandom_range(0, 15);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall, with one long hold-off when asked for
  always @(negedge clk) begin : drive_stall
    int hold_left;
    int pressure_seen;
    int w;
    bit rx_calm;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      pressure_seen = 0;
    end else if (pressure_seen != pressure_req) begin
      pressure_seen = pressure_req;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rec_taken) begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      w = (rush || rx_calm) ? 0 : $urandom_range(0, 15);
      if (w > 0) begin
        hold_left = w - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus helpers
  task automatic push_byte(input logic [ChW-1:0] c);
    pending_bytes.insert(pending_bytes.size(), '{ch: c, last: 1'b0});
    bytes_queued++;
  endtask

  task automatic end_string();
    pending_bytes[pending_bytes.size() - 1].last = 1'b1;
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
    end_string();
  endtask

  // any byte that is neither delimiter, blank nor quote
  function automatic logic [ChW-1:0] plain_byte();
    logic [ChW-1:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == delim || is_blank(b) || b == ChSquote || b == ChDquote)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [ChW-1:0] blank_byte();
    return $urandom_range(0, 1) ? ChSpace : ChTab;
  endfunction

  // fields separated by delimiter runs, the last quote left open if asked
  task automatic add_fields(input int nfields, input bit open_end);
    int             f;
    int             k;
    logic [ChW-1:0] q;
    for (f = 0; f < nfields; f++) begin
      repeat ($urandom_range(0, 2)) push_byte(blank_byte());
      case ($urandom_range(0, 5))
        0: begin
          // empty field
        end
        1, 2: begin
          for (k = $urandom_range(1, 6); k > 0; k--)
            push_byte((k > 1 && $urandom_range(0, 4) == 0) ? blank_byte() : plain_byte());
          repeat ($urandom_range(0, 2)) push_byte(blank_byte());
        end
        3, 4: begin
          q = $urandom_range(0, 1) ? ChDquote : ChSquote;
          push_byte(q);
          for (k = $urandom_range(0, 5); k > 0; k--) begin
            case ($urandom_range(0, 4))
              0: push_byte(delim);
              1: push_byte(q == ChDquote ? ChSquote : ChDquote);
              2: push_byte(blank_byte());
              default: push_byte(plain_byte());
            endcase
          end
          if (!(open_end && f == nfields - 1)) begin
            push_byte(q);
            repeat ($urandom_range(0, 2))
              push_byte($urandom_range(0, 1) ? plain_byte() : blank_byte());
          end
        end
        default: begin
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        end
      endcase
      if (f < nfields - 1) repeat ($urandom_range(1, 2)) push_byte(delim);
    end
  endtask

  task automatic add_string(input int nfields, input bit open_end);
    int base;
    base = bytes_queued;
    add_fields(nfields, open_end);
    if (bytes_queued == base) push_byte(plain_byte());
    end_string();
  endtask

  // mostly well-formed strings, some noise and some with an open quote
  task automatic random_strings(input int budget);
    int base;
    int pick;
    base = bytes_queued;
    while (bytes_queued - base < budget) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
        end_string();
      end else begin
        add_string($urandom_range(1, 5), pick == 1);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgDelim) delim = val[ChW-1:0];
    else max_tok = val;
  endtask

  task automatic set_regs(input logic [ChW-1:0] d, input logic [StartW-1:0] m);
    write_reg(CfgDelim, {8'($urandom_range(0, 255)), d});
    write_reg(CfgMaxTok, m);
  endtask

  // block drained: nothing to send, nothing outstanding, pipeline settled
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_recs.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin : stimulus
    int ph;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CfgDelim;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_ch        = '0;
    in_last      = 1'b0;
    out_stall    = 1'b0;
    byte_taken   = 1'b0;
    rec_taken    = 1'b0;
    rush         = 0;
    pressure_req = 0;
    bytes_queued = 0;
    mismatches   = 0;
    cycle_count  = 0;
    delim        = DelimReset;
    max_tok      = MaxTokReset;
    clear_string();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: blanks, quotes, junk after a quote, delimiter runs, open quote
    add_text("\t a b ,,'c,d'x,\"e");
    push_byte(8'hFF);
    end_string();
    push_byte(8'h00);
    end_string();
    add_text("''");
    add_text(" ");
    wait_idle();

    // fixed settings, then random ones
    for (ph = 0; ph < NumFixed + 4; ph++) begin
      if (ph < NumFixed) set_regs(FixedDelim[ph], FixedLimit[ph]);
      else set_regs(8'($urandom_range(0, 255)), 16'($urandom_range(0, 4)));
      if (ph == PressurePhase) begin
        rush = 1;
        pressure_req++;
      end
      random_strings(PhaseBytes);
      wait_idle();
      rush = 0;
    end

    // token limit changed in the middle of a string
    set_regs(8'd44, 16'd0);
    add_fields(3, 0);
    push_byte(delim);
    wait_idle();
    write_reg(CfgMaxTok, 16'd1);
    add_fields(3, 0);
    end_string();
    wait_idle();

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
